>>> hdl/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared constants and types of the Huffman code builder: default sizes,
// fixed port widths and the control bundle of the minimum search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package hcb_pkg;

    // default sizes handed to the top-level parameters
    localparam int MAX_SYMBOLS_DEF = 32;
    localparam int WEIGHT_BITS_DEF = 16;

    // fixed widths of the request and result fields
    localparam int WEIGHT_IN_W = 16;
    localparam int IDX_OUT_W   = 5;
    localparam int CODE_OUT_W  = 31;
    localparam int LEN_OUT_W   = 5;

    // control of one scan through the node table
    typedef struct packed {
        logic clear;   // restart the search, no candidate held
        logic valid;   // a node entry is presented this cycle
    } t_scan_ctl;

endpackage

`default_nettype wire

>>> hdl/hcb_node_table.sv
// ----------------------------------------------------------------------------
// hcb_node_table
// Node table of the Huffman tree: summed weight, parent and left child of
// each node, each in its own memory with one write port, read through one
// shared read address with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_node_table
    import hcb_pkg::*;
#(
    parameter int DEPTH = 2 * MAX_SYMBOLS_DEF,
    parameter int SUM_W = WEIGHT_BITS_DEF + $clog2(MAX_SYMBOLS_DEF)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_wt_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_wt_addr,
    input  wire logic [SUM_W-1:0]           i_wt_data,
    input  wire logic                       i_par_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_par_addr,
    input  wire logic [$clog2(DEPTH)-1:0]   i_par_data,
    input  wire logic                       i_lft_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_lft_addr,
    input  wire logic [$clog2(DEPTH)-1:0]   i_lft_data,
    input  wire logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic      [SUM_W-1:0]           o_rd_weight,
    output logic      [$clog2(DEPTH)-1:0]   o_rd_parent,
    output logic      [$clog2(DEPTH)-1:0]   o_rd_left
);

    localparam int AW = $clog2(DEPTH);

    logic [SUM_W-1:0] r_wt_mem  [DEPTH];
    logic [AW-1:0]    r_par_mem [DEPTH];
    logic [AW-1:0]    r_lft_mem [DEPTH];

    // weight memory
    always_ff @(posedge i_clk) begin
        if (i_wt_we) begin
            r_wt_mem[i_wt_addr] <= i_wt_data;
        end
        o_rd_weight <= r_wt_mem[i_rd_addr];
    end

    // parent memory
    always_ff @(posedge i_clk) begin
        if (i_par_we) begin
            r_par_mem[i_par_addr] <= i_par_data;
        end
        o_rd_parent <= r_par_mem[i_rd_addr];
    end

    // left child memory
    always_ff @(posedge i_clk) begin
        if (i_lft_we) begin
            r_lft_mem[i_lft_addr] <= i_lft_data;
        end
        o_rd_left <= r_lft_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

>>> hdl/hcb_min_unit.sv
// ----------------------------------------------------------------------------
// hcb_min_unit
// Shared compare unit: tracks the lightest parentless node seen during one
// scan, keeping the lowest index on equal weights and passing over one
// excluded node.
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_min_unit
    import hcb_pkg::*;
#(
    parameter int AW    = $clog2(2 * MAX_SYMBOLS_DEF),
    parameter int SUM_W = WEIGHT_BITS_DEF + $clog2(MAX_SYMBOLS_DEF)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_scan_ctl          i_ctl,
    input  wire logic [AW-1:0]      i_idx,
    input  wire logic [AW-1:0]      i_skip,
    input  wire logic [SUM_W-1:0]   i_weight,
    input  wire logic [AW-1:0]      i_parent,
    output logic      [AW-1:0]      o_best_idx,
    output logic      [SUM_W-1:0]   o_best_weight
);

    logic [AW-1:0]    r_best_idx;
    logic [SUM_W-1:0] r_best_w;
    logic             take;

    // index zero never takes part, so it marks "no candidate yet"
    assign take = i_ctl.valid && (i_parent == '0) && (i_idx != i_skip) &&
                  ((r_best_idx == '0) || (i_weight < r_best_w));

    // hold the best candidate index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_idx <= '0;
        end else if (i_ctl.clear) begin
            r_best_idx <= '0;
        end else if (take) begin
            r_best_idx <= i_idx;
        end
    end

    // hold the best candidate weight
    always_ff @(posedge i_clk) begin
        if (take && !i_ctl.clear) begin
            r_best_w <= i_weight;
        end
    end

    assign o_best_idx    = r_best_idx;
    assign o_best_weight = r_best_w;

endmodule

`default_nettype wire

>>> hdl/huffman_code_builder.sv
// ----------------------------------------------------------------------------
// huffman_code_builder
// Collects symbol weights, builds a Huffman tree in a node table and returns
// one code word and length per symbol in input order.
// ----------------------------------------------------------------------------
// Weights are taken one per cycle while collecting; the request marked last
// closes the set, and weights beyond MAX_SYMBOLS are dropped. For n symbols
// the tree build then runs n-1 merges; the merge that creates node i makes
// two passes over nodes 1..i-1 through the shared compare unit, reading the
// node table one entry a cycle. Each result then takes a walk from leaf to
// root, one table read per tree level, and waits until taken. No new weight
// is taken until the last result of the set has been delivered. A single
// symbol gets length zero.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_builder
    import hcb_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [WEIGHT_IN_W-1:0]  i_weight,
    input  wire logic                    i_last_weight,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic      [IDX_OUT_W-1:0]    o_symbol_index,
    output logic      [WEIGHT_IN_W-1:0]  o_symbol_weight,
    output logic      [CODE_OUT_W-1:0]   o_code_bits,
    output logic      [LEN_OUT_W-1:0]    o_code_length,
    output logic                         o_last_code
);

    localparam int DEPTH = 2 * MAX_SYMBOLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
    localparam int K_W   = $clog2(MAX_SYMBOLS);
    localparam int SUM_W = WEIGHT_BITS + $clog2(MAX_SYMBOLS);

    // sequencer states
    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_DRAIN = 4'd2;
    localparam logic [3:0] S_PICK  = 4'd3;
    localparam logic [3:0] S_MRG0  = 4'd4;
    localparam logic [3:0] S_MRG1  = 4'd5;
    localparam logic [3:0] S_MRG2  = 4'd6;
    localparam logic [3:0] S_ERD   = 4'd7;
    localparam logic [3:0] S_EEV   = 4'd8;
    localparam logic [3:0] S_WCHK  = 4'd9;
    localparam logic [3:0] S_WEV   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [AW-1:0]         r_node, n_node;      // node being created
    logic [AW-1:0]         r_top, n_top;        // last node of the tree
    logic [AW-1:0]         r_scan, n_scan;
    logic                  r_pass, n_pass;
    logic [AW-1:0]         r_a, n_a;
    logic [AW-1:0]         r_b, n_b;
    logic [SUM_W-1:0]      r_wa, n_wa;
    logic [SUM_W-1:0]      r_wb, n_wb;
    logic [K_W-1:0]        r_k, n_k;
    logic [AW-1:0]         r_child, n_child;
    logic [AW-1:0]         r_up, n_up;
    logic [CODE_OUT_W-1:0] r_code, n_code;
    logic [K_W-1:0]        r_len, n_len;
    logic [SUM_W-1:0]      r_sym_w, n_sym_w;
    logic                  r_rd_vld;
    logic [AW-1:0]         r_rd_idx;

    logic                  in_acc;
    logic                  store;
    logic [CNT_W-1:0]      new_count;
    logic [AW:0]           top_wide;
    logic [AW-1:0]         leaf_addr;
    logic [AW-1:0]         sym_addr;
    logic [K_W-1:0]        k_last;
    logic [WEIGHT_BITS+WEIGHT_IN_W-1:0] wt_ext;
    logic [SUM_W-1:0]      wt_in;

    logic                  wt_we, par_we, lft_we;
    logic [AW-1:0]         wt_addr, par_addr, lft_addr, par_data, lft_data;
    logic [SUM_W-1:0]      wt_data;
    logic [AW-1:0]         rd_addr;
    logic [SUM_W-1:0]      rd_weight;
    logic [AW-1:0]         rd_parent;
    logic [AW-1:0]         rd_left;

    t_scan_ctl             scan_ctl;
    logic [AW-1:0]         best_idx;
    logic [SUM_W-1:0]      best_w;

    logic [K_W+IDX_OUT_W-1:0]        idx_ext;
    logic [K_W+LEN_OUT_W-1:0]        len_ext;
    logic [SUM_W+WEIGHT_IN_W-1:0]    sw_ext;

    // request handshake and leaf bookkeeping
    assign in_acc    = i_valid && o_ready && (r_state == S_LOAD);
    assign store     = in_acc && (r_count < CNT_W'(MAX_SYMBOLS));
    assign new_count = store ? r_count + 1'b1 : r_count;
    assign top_wide  = (AW + 1)'({new_count, 1'b0}) - 1'b1;
    assign leaf_addr = AW'(r_count) + 1'b1;
    assign sym_addr  = AW'(r_k) + 1'b1;
    assign k_last    = K_W'(r_count - 1'b1);

    // keep only the low WEIGHT_BITS bits of the incoming weight
    assign wt_ext = {{WEIGHT_BITS{1'b0}}, i_weight};
    assign wt_in  = SUM_W'(wt_ext[WEIGHT_BITS-1:0]);

    // node table writes
    always_comb begin
        wt_we    = 1'b0;
        wt_addr  = leaf_addr;
        wt_data  = wt_in;
        par_we   = 1'b0;
        par_addr = leaf_addr;
        par_data = '0;
        lft_we   = 1'b0;
        lft_addr = leaf_addr;
        lft_data = '0;
        case (r_state)
            S_LOAD: begin
                wt_we  = store;
                par_we = store;
                lft_we = store;
            end
            S_MRG0: begin
                wt_we    = 1'b1;
                wt_addr  = r_node;
                wt_data  = r_wa + r_wb;
                par_we   = 1'b1;
                par_addr = r_a;
                par_data = r_node;
                lft_we   = 1'b1;
                lft_addr = r_node;
                lft_data = r_a;
            end
            S_MRG1: begin
                par_we   = 1'b1;
                par_addr = r_b;
                par_data = r_node;
            end
            S_MRG2: begin
                par_we   = 1'b1;
                par_addr = r_node;
                par_data = '0;
            end
            default: begin
            end
        endcase
    end

    // node table read address
    always_comb begin
        case (r_state)
            S_SCAN:  rd_addr = r_scan;
            S_ERD:   rd_addr = sym_addr;
            default: rd_addr = r_up;
        endcase
    end

    hcb_node_table #(
        .DEPTH (DEPTH),
        .SUM_W (SUM_W)
    ) u_table (
        .i_clk       (i_clk),
        .i_wt_we     (wt_we),
        .i_wt_addr   (wt_addr),
        .i_wt_data   (wt_data),
        .i_par_we    (par_we),
        .i_par_addr  (par_addr),
        .i_par_data  (par_data),
        .i_lft_we    (lft_we),
        .i_lft_addr  (lft_addr),
        .i_lft_data  (lft_data),
        .i_rd_addr   (rd_addr),
        .o_rd_weight (rd_weight),
        .o_rd_parent (rd_parent),
        .o_rd_left   (rd_left)
    );

    // track the entry in flight from the table to the compare unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_SCAN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_scan;
    end

    hcb_min_unit #(
        .AW    (AW),
        .SUM_W (SUM_W)
    ) u_min (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (scan_ctl),
        .i_idx         (r_rd_idx),
        .i_skip        (r_pass ? r_a : '0),
        .i_weight      (rd_weight),
        .i_parent      (rd_parent),
        .o_best_idx    (best_idx),
        .o_best_weight (best_w)
    );

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_node   = r_node;
        n_top    = r_top;
        n_scan   = r_scan;
        n_pass   = r_pass;
        n_a      = r_a;
        n_b      = r_b;
        n_wa     = r_wa;
        n_wb     = r_wb;
        n_k      = r_k;
        n_child  = r_child;
        n_up     = r_up;
        n_code   = r_code;
        n_len    = r_len;
        n_sym_w  = r_sym_w;
        scan_ctl = '{clear: 1'b0, valid: r_rd_vld};
        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    n_count = new_count;
                    if (i_last_weight) begin
                        n_top  = top_wide[AW-1:0];
                        n_node = AW'(new_count) + 1'b1;
                        n_scan = AW'(1);
                        n_pass = 1'b0;
                        n_k    = '0;
                        scan_ctl.clear = 1'b1;
                        // one symbol needs no merge
                        n_state = (new_count == CNT_W'(1)) ? S_ERD : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_scan == r_node - 1'b1) begin
                    n_state = S_DRAIN;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_PICK;
            end
            S_PICK: begin
                if (!r_pass) begin
                    n_a    = best_idx;
                    n_wa   = best_w;
                    n_pass = 1'b1;
                    n_scan = AW'(1);
                    scan_ctl.clear = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    n_b     = best_idx;
                    n_wb    = best_w;
                    n_state = S_MRG0;
                end
            end
            S_MRG0: begin
                n_state = S_MRG1;
            end
            S_MRG1: begin
                n_state = S_MRG2;
            end
            S_MRG2: begin
                if (r_node == r_top) begin
                    n_state = S_ERD;
                end else begin
                    n_node = r_node + 1'b1;
                    n_scan = AW'(1);
                    n_pass = 1'b0;
                    scan_ctl.clear = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_ERD: begin
                n_state = S_EEV;
            end
            S_EEV: begin
                n_sym_w = rd_weight;
                n_up    = rd_parent;
                n_child = sym_addr;
                n_code  = '0;
                n_len   = '0;
                n_state = S_WCHK;
            end
            S_WCHK: begin
                n_state = (r_up == '0) ? S_OUT : S_WEV;
            end
            S_WEV: begin
                // right child contributes a one at the current level
                if (rd_left != r_child) begin
                    n_code = r_code | (CODE_OUT_W'(1) << r_len);
                end
                n_len   = r_len + 1'b1;
                n_child = r_up;
                n_up    = rd_parent;
                n_state = S_WCHK;
            end
            S_OUT: begin
                if (i_ready) begin
                    if (r_k == k_last) begin
                        n_count = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_ERD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_pass  <= 1'b0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pass  <= n_pass;
            r_k     <= n_k;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_node  <= n_node;
        r_top   <= n_top;
        r_scan  <= n_scan;
        r_a     <= n_a;
        r_b     <= n_b;
        r_wa    <= n_wa;
        r_wb    <= n_wb;
        r_child <= n_child;
        r_up    <= n_up;
        r_code  <= n_code;
        r_len   <= n_len;
        r_sym_w <= n_sym_w;
    end

    // result fields, fitted to their port widths
    assign idx_ext = {{IDX_OUT_W{1'b0}}, r_k};
    assign len_ext = {{LEN_OUT_W{1'b0}}, r_len};
    assign sw_ext  = {{WEIGHT_IN_W{1'b0}}, r_sym_w};

    assign o_ready         = (r_state == S_LOAD);
    assign o_valid         = (r_state == S_OUT);
    assign o_symbol_index  = idx_ext[IDX_OUT_W-1:0];
    assign o_symbol_weight = sw_ext[WEIGHT_IN_W-1:0];
    assign o_code_bits     = r_code;
    assign o_code_length   = len_ext[LEN_OUT_W-1:0];
    assign o_last_code     = (r_k == k_last);

endmodule

`default_nettype wire

>>> dv/tb_huffman_code_builder.sv
// ----------------------------------------------------------------------------
// tb_huffman_code_builder
// Self-checking bench for the Huffman code builder: sends weight sets, runs
// its own tree build on every closed set, and checks each returned code.
// ----------------------------------------------------------------------------
// A queue of weight requests is filled up front: a short directed part
// (lone symbol, zero weights, ties, extreme weights, a skewed set), then
// random sets in four idling phases. Random sets include tie-heavy sets,
// Fibonacci sets that give long codes, and sets past capacity. A clocked
// driver presents the requests, and a clocked monitor compares every result
// with the oldest awaited code. The first set of each random phase waits
// until all awaited codes have come back.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_huffman_code_builder;
    timeunit 1ns;
    timeprecision 1ps;

    import hcb_pkg::*;

    localparam int SYMBOLS       = MAX_SYMBOLS_DEF;
    localparam int NODES         = 2 * SYMBOLS;
    localparam int IDLE_PCT      = 57;
    localparam int BOTH_IDLE_PCT = 26;
    localparam int QUIET_LIMIT   = 20000;
    localparam int DRAIN_CYCLES  = 300;
    localparam int FIB_MAX       = 24;

    typedef enum int {
        PH_STEADY,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH_IDLE
    } t_phase;

    typedef enum int {
        MIX_FULL,
        MIX_TIES,
        MIX_FIB
    } t_weight_mix;

    typedef struct {
        logic [WEIGHT_IN_W-1:0] weight;
        logic                   last;
        t_phase                 phase;
        bit                     drain;
    } t_weight_req;

    typedef struct {
        logic [IDX_OUT_W-1:0]   index;
        logic [WEIGHT_IN_W-1:0] weight;
        logic [CODE_OUT_W-1:0]  code;
        logic [LEN_OUT_W-1:0]   length;
        logic                   last;
    } t_code_word;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [WEIGHT_IN_W-1:0] i_weight = '0;
    logic                   i_last_weight = 1'b0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [IDX_OUT_W-1:0]   o_symbol_index;
    logic [WEIGHT_IN_W-1:0] o_symbol_weight;
    logic [CODE_OUT_W-1:0]  o_code_bits;
    logic [LEN_OUT_W-1:0]   o_code_length;
    logic                   o_last_code;

    t_weight_req queued_weights[$];
    t_code_word  awaited_codes[$];
    t_phase      cur_phase = PH_STEADY;

    // set under collection and the tree built from it
    logic [WEIGHT_IN_W-1:0] set_weight[SYMBOLS];
    int                     set_size = 0;
    logic [20:0]            tree_weight[NODES];
    int                     tree_parent[NODES];
    int                     tree_left[NODES];

    int mismatch_count = 0;
    int req_count      = 0;
    int dropped_reqs   = 0;
    int sets_closed    = 0;
    int codes_checked  = 0;
    int longest_code   = 0;
    int quiet_cycles   = 0;

    huffman_code_builder u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_weight       (i_weight),
        .i_last_weight  (i_last_weight),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_symbol_index (o_symbol_index),
        .o_symbol_weight(o_symbol_weight),
        .o_code_bits    (o_code_bits),
        .o_code_length  (o_code_length),
        .o_last_code    (o_last_code)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // roll whether one side idles this cycle, by phase
    function automatic bit idle_now(input t_phase ph, input bit sender);
        int pct;
        pct = 0;
        if (ph == PH_BOTH_IDLE) begin
            pct = BOTH_IDLE_PCT;
        end else if (sender && ph == PH_SEND_IDLE) begin
            pct = IDLE_PCT;
        end else if (!sender && ph == PH_RECV_STALL) begin
            pct = IDLE_PCT;
        end
        return $urandom_range(0, 99) < pct;
    endfunction

    // lightest node without a parent among 1..top, lower index wins ties
    function automatic int lightest_free(input int top, input int skip);
        int best;
        int k;
        best = 0;
        for (k = 1; k <= top; k++) begin
            if (tree_parent[k] == 0 && k != skip &&
                (best == 0 || tree_weight[k] < tree_weight[best])) begin
                best = k;
            end
        end
        return best;
    endfunction

    // build the tree for the closed set and queue one code per symbol
    task automatic build_code_table();
        int          i;
        int          a;
        int          b;
        int          child;
        int          up;
        int          len;
        logic [30:0] bits;
        t_code_word  cw;
        for (i = 1; i <= set_size; i++) begin
            tree_weight[i] = set_weight[i-1];
            tree_parent[i] = 0;
            tree_left[i]   = 0;
        end
        for (i = set_size + 1; i <= 2 * set_size - 1; i++) begin
            a = lightest_free(i - 1, 0);
            b = lightest_free(i - 1, a);
            tree_parent[a] = i;
            tree_parent[b] = i;
            tree_left[i]   = a;
            tree_parent[i] = 0;
            tree_weight[i] = tree_weight[a] + tree_weight[b];
        end
        // walk leaf to root, first code bit ends up on top
        for (i = 0; i < set_size; i++) begin
            child = i + 1;
            up    = tree_parent[child];
            bits  = '0;
            len   = 0;
            while (up != 0) begin
                if (tree_left[up] != child && len < CODE_OUT_W) begin
                    bits[len] = 1'b1;
                end
                len++;
                child = up;
                up    = tree_parent[up];
            end
            cw.index  = i[IDX_OUT_W-1:0];
            cw.weight = set_weight[i];
            cw.code   = bits;
            cw.length = len[LEN_OUT_W-1:0];
            cw.last   = (i == set_size - 1);
            awaited_codes.push_back(cw);
        end
    endtask

    task automatic push_req(input logic [WEIGHT_IN_W-1:0] w, input logic last,
                            input t_phase ph, input bit drain);
        t_weight_req req;
        req.weight = w;
        req.last   = last;
        req.phase  = ph;
        req.drain  = drain;
        queued_weights.push_back(req);
    endtask

    task automatic add_set(input int count, input t_weight_mix mix, input t_phase ph,
                           input bit drain);
        int                     fib_seq[FIB_MAX];
        int                     i;
        int                     pick;
        bit                     reversed;
        logic [WEIGHT_IN_W-1:0] w;
        fib_seq[0] = 1;
        fib_seq[1] = 1;
        for (i = 2; i < FIB_MAX; i++) begin
            fib_seq[i] = fib_seq[i-1] + fib_seq[i-2];
        end
        reversed = 1'($urandom_range(0, 1));
        for (i = 0; i < count; i++) begin
            case (mix)
                MIX_TIES: begin
                    w = WEIGHT_IN_W'($urandom_range(0, 3));
                end
                MIX_FIB: begin
                    if (count <= FIB_MAX) begin
                        w = WEIGHT_IN_W'(fib_seq[reversed ? count - 1 - i : i]);
                    end else begin
                        w = WEIGHT_IN_W'($urandom_range(0, 65535));
                    end
                end
                default: begin
                    pick = $urandom_range(0, 15);
                    if (pick == 0) begin
                        w = '0;
                    end else if (pick == 1) begin
                        w = '1;
                    end else begin
                        w = WEIGHT_IN_W'($urandom_range(0, 65535));
                    end
                end
            endcase
            push_req(w, i == count - 1, ph, drain && i == 0);
        end
    endtask

    // driver: present queued weight requests, idle between them by phase
    always @(posedge i_clk) begin : drive_weights
        bit          took;
        bit          launch;
        t_weight_req nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            took = i_valid && o_ready;
            if (took) begin
                req_count++;
                if (set_size < SYMBOLS) begin
                    set_weight[set_size] = i_weight;
                    set_size++;
                end else begin
                    dropped_reqs++;
                end
                if (i_last_weight) begin
                    build_code_table();
                    set_size = 0;
                    sets_closed++;
                end
            end
            if (!i_valid || took) begin
                launch = 1'b0;
                if (queued_weights.size() != 0) begin
                    cur_phase = queued_weights[0].phase;
                    launch = !(queued_weights[0].drain && awaited_codes.size() != 0);
                    if (idle_now(cur_phase, 1'b1)) begin
                        launch = 1'b0;
                    end
                end
                if (launch) begin
                    nxt = queued_weights.pop_front();
                    i_valid       <= 1'b1;
                    i_weight      <= nxt.weight;
                    i_last_weight <= nxt.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: take results, stall by phase, compare with the oldest awaited code
    always @(posedge i_clk) begin : check_codes
        t_code_word want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (awaited_codes.size() == 0) begin
                    report_mismatch($sformatf("result for symbol %0d with nothing awaited",
                                              o_symbol_index));
                end else begin
                    want = awaited_codes.pop_front();
                    if (o_symbol_index !== want.index)
                        report_mismatch($sformatf("symbol_index got %0d want %0d",
                                                  o_symbol_index, want.index));
                    if (o_symbol_weight !== want.weight)
                        report_mismatch($sformatf("symbol %0d weight got %0h want %0h",
                                                  want.index, o_symbol_weight, want.weight));
                    if (o_code_bits !== want.code)
                        report_mismatch($sformatf("symbol %0d code_bits got %0h want %0h",
                                                  want.index, o_code_bits, want.code));
                    if (o_code_length !== want.length)
                        report_mismatch($sformatf("symbol %0d code_length got %0d want %0d",
                                                  want.index, o_code_length, want.length));
                    if (o_last_code !== want.last)
                        report_mismatch($sformatf("symbol %0d last_code got %0b want %0b",
                                                  want.index, o_last_code, want.last));
                    codes_checked++;
                    if (want.length > longest_code) begin
                        longest_code = want.length;
                    end
                end
            end
            if (idle_now(cur_phase, 1'b0)) begin
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // watchdog: end the run if neither channel moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: nothing moved for %0d cycles, %0d codes still awaited",
                         quiet_cycles, awaited_codes.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin : run_test
        int     p;
        int     roll;
        int     start_items;
        bit     first;
        t_phase ph;

        // directed: lone symbol, zero pair, four-way tie, extremes, skewed set
        push_req(16'hFFFF, 1'b1, PH_STEADY, 1'b0);
        push_req(16'h0000, 1'b0, PH_STEADY, 1'b0);
        push_req(16'h0000, 1'b1, PH_STEADY, 1'b0);
        for (p = 0; p < 4; p++) begin
            push_req(16'd5, p == 3, PH_STEADY, 1'b0);
        end
        push_req(16'hFFFF, 1'b0, PH_STEADY, 1'b0);
        push_req(16'h0000, 1'b0, PH_STEADY, 1'b0);
        push_req(16'h8000, 1'b0, PH_STEADY, 1'b0);
        push_req(16'h7FFF, 1'b0, PH_STEADY, 1'b0);
        push_req(16'h0001, 1'b1, PH_STEADY, 1'b0);
        add_set(7, MIX_FIB, PH_STEADY, 1'b0);

        // random sets per idling phase; the first set of each waits for a drain
        for (p = 0; p < 4; p++) begin
            ph          = t_phase'(p);
            first       = 1'b1;
            start_items = queued_weights.size();
            while (queued_weights.size() - start_items < 60) begin
                roll = $urandom_range(0, 99);
                if (first && ph == PH_SEND_IDLE) begin
                    add_set(SYMBOLS + 1, MIX_FULL, ph, 1'b1);
                end else if (first && ph == PH_RECV_STALL) begin
                    add_set(SYMBOLS + 4, MIX_TIES, ph, 1'b1);
                end else if (roll < 5) begin
                    add_set($urandom_range(SYMBOLS, SYMBOLS + 4), MIX_FULL, ph, first);
                end else if (roll < 15) begin
                    add_set($urandom_range(12, FIB_MAX), MIX_FIB, ph, first);
                end else if (roll < 40) begin
                    add_set($urandom_range(2, 10), MIX_TIES, ph, first);
                end else begin
                    add_set($urandom_range(1, 10), MIX_FULL, ph, first);
                end
                first = 1'b0;
            end
        end

        // hold reset, then release
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (queued_weights.size() != 0 || i_valid) @(posedge i_clk);
        while (awaited_codes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d weight requests in %0d sets, %0d dropped past capacity.",
                 req_count, sets_closed, dropped_reqs);
        $display("Checked %0d codes, longest %0d bits, %0d mismatches.",
                 codes_checked, longest_code, mismatch_count);
        if (mismatch_count == 0 && awaited_codes.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
